/* rtl/peak_velocity_magnitude_hold_top_macros.svh */
// Assertion macros used by the peak velocity hold RTL.
// Each macro samples on the rising edge of clk_i and is disabled during reset.
`ifndef PEAK_VELOCITY_MAGNITUDE_HOLD_TOP_MACROS_SVH
`define PEAK_VELOCITY_MAGNITUDE_HOLD_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// General property check.
`define PVMH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pvmh assertion failed");
// Condition that must never be true.
`define PVMH_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pvmh assertion failed");
`else
`define PVMH_ASSERT(lbl, prop)
`define PVMH_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/pvmh_pkg.sv */
package pvmh_pkg;

  // Field widths.
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned PEAK_W     = 24;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned GRID_W     = 9;
  localparam int unsigned SCALE_W    = 18;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned NUM_AXES   = 3;

  // Square root: result bits resolved in each pipeline stage.
  localparam int unsigned SQRT_STEPS = 2;

  // Default store geometry.
  localparam int unsigned MAX_COLUMNS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF    = 256;

  // Register reset values.
  localparam logic [GRID_W-1:0]  GRID_COLUMNS_RST   = 9'd256;
  localparam logic [GRID_W-1:0]  GRID_ROWS_RST      = 9'd256;
  localparam logic [SCALE_W-1:0] VELOCITY_SCALE_RST = 18'd65536;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLUMNS   = 2'd0,
    REG_GRID_ROWS      = 2'd1,
    REG_VELOCITY_SCALE = 2'd2
  } pvmh_reg_e;

  // Pipeline control that travels with each sample.
  typedef struct packed {
    logic valid;
    logic oog;
  } pvmh_ctl_t;

  typedef struct packed {
    logic [COORD_W-1:0]         column;
    logic [COORD_W-1:0]         row;
    logic signed [SAMPLE_W-1:0] vel_x;
    logic signed [SAMPLE_W-1:0] vel_y;
    logic signed [SAMPLE_W-1:0] vel_z;
  } pvmh_in_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak_horizontal;
    logic [PEAK_W-1:0] peak_total;
    logic              out_of_grid;
  } pvmh_out_t;

endpackage

/* rtl/pvmh_scale.sv */
module pvmh_scale import pvmh_pkg::*; #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [SCALE_W-1:0]                  scale_i,
  input  pvmh_ctl_t                           ctl_i,
  input  logic [ADDR_W-1:0]                   addr_i,
  input  logic [NUM_AXES-1:0][SAMPLE_W-1:0]   vel_i,
  output pvmh_ctl_t                           ctl_o,
  output logic [ADDR_W-1:0]                   addr_o,
  output logic [2*SAMPLE_W-1:0]               hsq_o,
  output logic [2*SAMPLE_W-1:0]               tsq_o
);

  localparam int unsigned STAGES = 5;
  localparam int unsigned PROD_W = SAMPLE_W + SCALE_W;
  localparam int unsigned SHR_W  = PROD_W - FRAC_W;
  localparam int unsigned SQ_W   = 2 * SAMPLE_W;
  localparam logic [SHR_W-1:0] LIM_POS = SHR_W'((64'd1 << (SAMPLE_W - 1)) - 64'd1);
  localparam logic [SHR_W-1:0] LIM_NEG = SHR_W'(64'd1 << (SAMPLE_W - 1));

  pvmh_ctl_t          ctl_q  [STAGES];
  logic [ADDR_W-1:0]  addr_q [STAGES];

  logic [NUM_AXES-1:0] neg_d, neg1_q, neg2_q;
  logic [SAMPLE_W-1:0] mag_d  [NUM_AXES];
  logic [SAMPLE_W-1:0] mag_q  [NUM_AXES];
  logic [PROD_W-1:0]   full_d [NUM_AXES];
  logic [SHR_W-1:0]    prod_q [NUM_AXES];
  logic [SHR_W-1:0]    lim_d  [NUM_AXES];
  logic [SAMPLE_W-1:0] sat_d  [NUM_AXES];
  logic [SAMPLE_W-1:0] sat_q  [NUM_AXES];
  logic [SQ_W-1:0]     sq_d   [NUM_AXES];
  logic [SQ_W-1:0]     sq_q   [NUM_AXES];
  logic [SQ_W-1:0]     hsq_d, tsq_d, hsq_q, tsq_q;

  // Magnitude, scaled product, saturation and squares per axis.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      neg_d[i]  = vel_i[i][SAMPLE_W-1];
      mag_d[i]  = neg_d[i] ? (~vel_i[i] + SAMPLE_W'(1)) : vel_i[i];
      full_d[i] = PROD_W'(mag_q[i]) * PROD_W'(scale_i);
      lim_d[i]  = neg2_q[i] ? LIM_NEG : LIM_POS;
      sat_d[i]  = (prod_q[i] > lim_d[i]) ? lim_d[i][SAMPLE_W-1:0]
                                         : prod_q[i][SAMPLE_W-1:0];
      sq_d[i]   = SQ_W'(sat_q[i]) * SQ_W'(sat_q[i]);
    end
    hsq_d = sq_q[0] + sq_q[1];
    tsq_d = sq_q[0] + sq_q[1] + sq_q[2];
  end

  // Control travels alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) begin
        ctl_q[k] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_i;
      for (int k = 1; k < STAGES; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    addr_q[0] <= addr_i;
    for (int k = 1; k < STAGES; k++) begin
      addr_q[k] <= addr_q[k-1];
    end
    neg1_q <= neg_d;
    neg2_q <= neg1_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      mag_q[i]  <= mag_d[i];
      prod_q[i] <= full_d[i][PROD_W-1:FRAC_W];
      sat_q[i]  <= sat_d[i];
      sq_q[i]   <= sq_d[i];
    end
    hsq_q <= hsq_d;
    tsq_q <= tsq_d;
  end

  assign ctl_o  = ctl_q[STAGES-1];
  assign addr_o = addr_q[STAGES-1];
  assign hsq_o  = hsq_q;
  assign tsq_o  = tsq_q;

endmodule

/* rtl/pvmh_sqrt.sv */
module pvmh_sqrt import pvmh_pkg::*; #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pvmh_ctl_t              ctl_i,
  input  logic [ADDR_W-1:0]      addr_i,
  input  logic [2*SAMPLE_W-1:0]  hsq_i,
  input  logic [2*SAMPLE_W-1:0]  tsq_i,
  output pvmh_ctl_t              ctl_o,
  output logic [ADDR_W-1:0]      addr_o,
  output logic [SAMPLE_W-1:0]    h_o,
  output logic [SAMPLE_W-1:0]    t_o
);

  localparam int unsigned W     = SAMPLE_W;
  localparam int unsigned RAD_W = 2 * W;
  localparam int unsigned RW    = W + 3;
  localparam int unsigned NST   = W / SQRT_STEPS;
  localparam int unsigned LANES = 2;

  pvmh_ctl_t         ctl_q  [NST];
  logic [ADDR_W-1:0] addr_q [NST];

  logic [RAD_W-1:0] rad_s  [NST][LANES];
  logic [RW-1:0]    rem_s  [NST][LANES];
  logic [W-1:0]     root_s [NST][LANES];
  logic [RAD_W-1:0] rad_d  [NST][LANES];
  logic [RW-1:0]    rem_d  [NST][LANES];
  logic [W-1:0]     root_d [NST][LANES];
  logic [RAD_W-1:0] rad_q  [NST][LANES];
  logic [RW-1:0]    rem_q  [NST][LANES];
  logic [W-1:0]     root_q [NST][LANES];

  // Stage inputs: the first stage starts a fresh root, later ones continue.
  always_comb begin
    rad_s[0][0] = hsq_i;
    rad_s[0][1] = tsq_i;
    for (int l = 0; l < LANES; l++) begin
      rem_s[0][l]  = '0;
      root_s[0][l] = '0;
    end
    for (int s = 1; s < NST; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rad_s[s][l]  = rad_q[s-1][l];
        rem_s[s][l]  = rem_q[s-1][l];
        root_s[s][l] = root_q[s-1][l];
      end
    end
  end

  // Restoring square root: each step brings down two radicand bits and
  // decides one root bit.
  always_comb begin
    logic [RAD_W-1:0] rad_v;
    logic [RW-1:0]    rem_v;
    logic [RW-1:0]    trial_v;
    logic [W-1:0]     root_v;
    for (int s = 0; s < NST; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rad_v  = rad_s[s][l];
        rem_v  = rem_s[s][l];
        root_v = root_s[s][l];
        for (int k = 0; k < SQRT_STEPS; k++) begin
          rem_v   = {rem_v[RW-3:0], rad_v[RAD_W-1 -: 2]};
          rad_v   = {rad_v[RAD_W-3:0], 2'b00};
          trial_v = {RW'(root_v) << 2} | RW'(1);
          if (rem_v >= trial_v) begin
            rem_v  = rem_v - trial_v;
            root_v = {root_v[W-2:0], 1'b1};
          end else begin
            root_v = {root_v[W-2:0], 1'b0};
          end
        end
        rad_d[s][l]  = rad_v;
        rem_d[s][l]  = rem_v;
        root_d[s][l] = root_v;
      end
    end
  end

  // Control pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) begin
        ctl_q[s] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < NST; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  // Datapath pipeline.
  always_ff @(posedge clk_i) begin
    addr_q[0] <= addr_i;
    for (int s = 1; s < NST; s++) begin
      addr_q[s] <= addr_q[s-1];
    end
    for (int s = 0; s < NST; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rad_q[s][l]  <= rad_d[s][l];
        rem_q[s][l]  <= rem_d[s][l];
        root_q[s][l] <= root_d[s][l];
      end
    end
  end

  assign ctl_o  = ctl_q[NST-1];
  assign addr_o = addr_q[NST-1];
  assign h_o    = root_q[NST-1][0];
  assign t_o    = root_q[NST-1][1];

endmodule

/* rtl/pvmh_peak_mem.sv */
`include "peak_velocity_magnitude_hold_top_macros.svh"

module pvmh_peak_mem import pvmh_pkg::*; #(
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DEPTH  = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pvmh_ctl_t            ctl_i,
  input  logic [ADDR_W-1:0]    addr_i,
  input  logic [SAMPLE_W-1:0]  h_i,
  input  logic [SAMPLE_W-1:0]  t_i,
  output logic                 clearing_o,
  output logic                 done_o,
  output pvmh_out_t            result_o
);

  localparam int unsigned WORD_W = 2 * PEAK_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Both peaks of a point share one memory word: horizontal high, total low.
  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  logic              clr_active_q, clr_active_d;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;

  pvmh_ctl_t         r_ctl_q;
  logic [ADDR_W-1:0] r_addr_q;
  logic [PEAK_W-1:0] r_h_q, r_t_q;

  logic              fwd_vld_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  logic [WORD_W-1:0] fwd_data_q;

  logic              done_q;
  pvmh_out_t         result_q, result_d;

  logic              rd_en, wr_upd, wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data, old_word, new_word;
  logic [PEAK_W-1:0] old_h, old_t, new_h, new_t;

  // Clearing pass after reset, one entry per cycle.
  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == LAST_ADDR) begin
        clr_active_d = 1'b0;
      end
    end
  end

  // Read-modify-write: the entry written in the previous cycle is forwarded,
  // since the memory returned the value from before that write.
  always_comb begin
    rd_en    = ctl_i.valid && !ctl_i.oog;
    wr_upd   = r_ctl_q.valid && !r_ctl_q.oog;
    old_word = (fwd_vld_q && (fwd_addr_q == r_addr_q)) ? fwd_data_q : rd_data_q;
    old_h    = old_word[WORD_W-1:PEAK_W];
    old_t    = old_word[PEAK_W-1:0];
    new_h    = (old_h < r_h_q) ? r_h_q : old_h;
    new_t    = (old_t < r_t_q) ? r_t_q : old_t;
    new_word = {new_h, new_t};
    wr_en    = clr_active_q || wr_upd;
    wr_addr  = clr_active_q ? clr_addr_q : r_addr_q;
    wr_data  = clr_active_q ? '0 : new_word;

    result_d.peak_horizontal = r_ctl_q.oog ? '0 : new_h;
    result_d.peak_total      = r_ctl_q.oog ? '0 : new_t;
    result_d.out_of_grid     = r_ctl_q.oog;
  end

  // Peak store.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
      r_ctl_q      <= '0;
      fwd_vld_q    <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
      r_ctl_q      <= ctl_i;
      fwd_vld_q    <= wr_upd;
      done_q       <= r_ctl_q.valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    r_addr_q   <= addr_i;
    r_h_q      <= h_i;
    r_t_q      <= t_i;
    fwd_addr_q <= r_addr_q;
    fwd_data_q <= new_word;
    result_q   <= result_d;
  end

  assign clearing_o = clr_active_q;
  assign done_o     = done_q;
  assign result_o   = result_q;

  // The pipeline stays empty while the store is being cleared.
  `PVMH_ASSERT_NEVER(a_no_item_in_clear, clr_active_q && (ctl_i.valid || r_ctl_q.valid))
  // The clearing pass only ends after the last entry.
  `PVMH_ASSERT(a_clear_covers_store, $fell(clr_active_q) |-> $past(clr_addr_q) == LAST_ADDR)
  // The stored horizontal peak never drops below the horizontal magnitude just seen.
  `PVMH_ASSERT(a_peak_covers_input, wr_upd |=> result_q.peak_horizontal >= $past(r_h_q))
  // The total magnitude always dominates the horizontal one.
  `PVMH_ASSERT(a_total_dominates,
               done_q |-> result_q.peak_total >= result_q.peak_horizontal)

endmodule

/* rtl/peak_velocity_magnitude_hold_top.sv */
// Peak ground velocity hold over a surface grid.
// A sample (column, row and three signed velocity components) is taken at a
// rising edge where start_i is high and busy_o is low. Each component is scaled
// by the Q2.16 velocity_scale register and saturated, the horizontal and total
// magnitudes are taken as truncated integer square roots, and the point's stored
// peaks are raised where the new magnitude is larger.
// One result per sample appears on result_o with done_o high for exactly one
// cycle, in input order. A point outside the configured grid returns
// out_of_grid with both peaks zero and stores nothing. The receiver cannot
// stall, so nothing ever backs up. Throughput is one sample per clock once the
// clearing pass is over: the datapath is fully pipelined, the square root
// resolves two bits per stage over twelve stages, and the peak store does one
// read and one write per cycle with forwarding between back-to-back updates
// of the same point.
// After reset busy_o stays high while all MAX_COLUMNS * MAX_ROWS entries of the
// peak store (65536 by default) are swept to zero. Configuration transfers
// (cfg_valid_i, cfg_index_i, cfg_data_i) are always accepted and are meant
// to happen only while no sample is in flight.
module peak_velocity_magnitude_hold_top import pvmh_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  pvmh_in_t              sample_i,
  output logic                  done_o,
  output pvmh_out_t             result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [GRID_W-1:0]  grid_columns_q;
  logic [GRID_W-1:0]  grid_rows_q;
  logic [SCALE_W-1:0] velocity_scale_q;

  pvmh_ctl_t                         s0_ctl_q, s0_ctl_d;
  logic [ADDR_W-1:0]                 s0_addr_q, s0_addr_d;
  logic [NUM_AXES-1:0][SAMPLE_W-1:0] s0_vel_q;

  pvmh_ctl_t               sc_ctl, sq_ctl;
  logic [ADDR_W-1:0]       sc_addr, sq_addr;
  logic [2*SAMPLE_W-1:0]   hsq, tsq;
  logic [SAMPLE_W-1:0]     h_root, t_root;
  logic                    clearing;

  assign busy_o      = clearing;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q   <= GRID_COLUMNS_RST;
      grid_rows_q      <= GRID_ROWS_RST;
      velocity_scale_q <= VELOCITY_SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GRID_COLUMNS:   grid_columns_q   <= cfg_data_i[GRID_W-1:0];
        REG_GRID_ROWS:      grid_rows_q      <= cfg_data_i[GRID_W-1:0];
        REG_VELOCITY_SCALE: velocity_scale_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid check and store address of an accepted sample.
  always_comb begin
    s0_ctl_d.valid = start_i && !busy_o;
    s0_ctl_d.oog   = ({1'b0, sample_i.column} >= grid_columns_q) ||
                     ({1'b0, sample_i.row} >= grid_rows_q) ||
                     (32'(sample_i.column) >= MAX_COLUMNS) ||
                     (32'(sample_i.row) >= MAX_ROWS);
    s0_addr_d      = ADDR_W'(32'(sample_i.row) * MAX_COLUMNS + 32'(sample_i.column));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else begin
      s0_ctl_q <= s0_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_addr_q   <= s0_addr_d;
    s0_vel_q[0] <= sample_i.vel_x;
    s0_vel_q[1] <= sample_i.vel_y;
    s0_vel_q[2] <= sample_i.vel_z;
  end

  // Scaling, saturation and sums of squares.
  pvmh_scale #(
    .ADDR_W (ADDR_W)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scale_i (velocity_scale_q),
    .ctl_i   (s0_ctl_q),
    .addr_i  (s0_addr_q),
    .vel_i   (s0_vel_q),
    .ctl_o   (sc_ctl),
    .addr_o  (sc_addr),
    .hsq_o   (hsq),
    .tsq_o   (tsq)
  );

  // Pipelined square roots of both magnitudes.
  pvmh_sqrt #(
    .ADDR_W (ADDR_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sc_ctl),
    .addr_i (sc_addr),
    .hsq_i  (hsq),
    .tsq_i  (tsq),
    .ctl_o  (sq_ctl),
    .addr_o (sq_addr),
    .h_o    (h_root),
    .t_o    (t_root)
  );

  // Peak store update and result register.
  pvmh_peak_mem #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_peak_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sq_ctl),
    .addr_i     (sq_addr),
    .h_i        (h_root),
    .t_i        (t_root),
    .clearing_o (clearing),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule
